FILE: hw/rtl/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

    localparam int SEQ_SPACE  = 8;
    localparam int SEQ_W      = 3;
    localparam int CNT_W      = 4;
    localparam int WINDOW     = 4;
    localparam int DATA_WIDTH = 64;

    localparam logic [63:0] DATA_MASK = {64{1'b1}} >> (64 - DATA_WIDTH);
    localparam logic [SEQ_W-1:0] WINDOW_MOD = SEQ_W'(WINDOW % SEQ_SPACE);
    localparam logic [1:0] DUP_LAST = 2'd2;

    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [2:0] KIND_NEW     = 3'd0;
    localparam logic [2:0] KIND_REFUSED = 3'd1;
    localparam logic [2:0] KIND_RESENT  = 3'd2;
    localparam logic [2:0] KIND_ACK_OK  = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;
    localparam logic [2:0] KIND_IDLE_TO = 3'd5;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [63:0]      payload;
        logic [SEQ_W-1:0] ack_num;
        logic             ack_good;
        logic [SEQ_W-1:0] timeout_seq;
    } item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [SEQ_W-1:0] seq;
        logic [63:0]      data_out;
        logic             timer_stop;
        logic             timer_start;
        logic [SEQ_W-1:0] timer_seq;
        logic             window_full;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gbn_store.sv
`default_nettype none

module gbn_store (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [gbn_pkg::SEQ_W-1:0] waddr,
    input  wire logic [63:0]               wdata,
    input  wire logic [gbn_pkg::SEQ_W-1:0] raddr,
    output logic      [63:0]               rdata
);

    logic [63:0] mem [gbn_pkg::SEQ_SPACE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/go_back_n_sender_window.sv
// Go-Back-N sender over an 8-number sequence space with a window of 4 packets.
// Each input beat (send, acknowledgement or timer expiry) is taken when the
// block is idle and answered by one to four result beats, the final one
// marked by last. An input answered by a single beat passes through the
// execute state back to idle; an accepted acknowledgement that leaves
// packets outstanding goes on through a second acknowledgement state; a
// retransmission walks the outstanding packets through the single read port
// of the packet store, one stored packet per cycle while the result side
// takes them. A stalled result side holds the sequencer.
`default_nettype none

module go_back_n_sender_window (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire gbn_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output gbn_pkg::result_t      result
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_ACK2   = 4'b0100,
        ST_RESEND = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    gbn_pkg::item_t   item_reg;
    gbn_pkg::result_t result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic [gbn_pkg::SEQ_W-1:0] base_reg, base_next;
    logic [gbn_pkg::SEQ_W-1:0] nseq_reg, nseq_next;
    logic                      full_reg, full_next;
    logic [1:0]                dup_reg, dup_next;
    logic [gbn_pkg::SEQ_W-1:0] idx_reg, idx_next;
    logic [gbn_pkg::CNT_W-1:0] rs_n_reg, rs_n_next;
    logic [gbn_pkg::SEQ_W-1:0] rs_tseq_reg, rs_tseq_next;

    logic                      we;
    logic [gbn_pkg::SEQ_W-1:0] raddr;
    logic [63:0]               rdata;

    logic                      out_free;
    logic                      emit;
    logic [gbn_pkg::CNT_W-1:0] cnt;
    logic [gbn_pkg::SEQ_W-1:0] diff;
    logic [gbn_pkg::SEQ_W-1:0] off;
    logic [gbn_pkg::SEQ_W-1:0] seq_inc;
    logic [gbn_pkg::SEQ_W-1:0] base_new;
    logic                      rs_final;

    gbn_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (nseq_reg),
        .wdata (item_reg.payload & gbn_pkg::DATA_MASK),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    assign diff     = nseq_reg - base_reg;
    assign cnt      = (diff == '0 && full_reg) ? gbn_pkg::CNT_W'(gbn_pkg::SEQ_SPACE)
                                               : {1'b0, diff};
    assign off      = item_reg.ack_num - base_reg;
    assign seq_inc  = nseq_reg + 1'b1;
    assign base_new = item_reg.ack_num + 1'b1;
    assign rs_final = (({1'b0, idx_reg} + 1'b1) == rs_n_reg);

    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        nseq_next    = nseq_reg;
        full_next    = full_reg;
        dup_next     = dup_reg;
        idx_next     = idx_reg;
        rs_n_next    = rs_n_reg;
        rs_tseq_next = rs_tseq_reg;
        we           = 1'b0;
        raddr        = base_reg + idx_reg;
        emit         = 1'b0;
        result_next  = '0;
        result_next.window_full = full_reg;
        result_next.last        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                raddr = base_reg;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    emit       = 1'b1;
                    result_next.kind = gbn_pkg::KIND_IGNORED;
                    case (item_reg.cmd)
                        gbn_pkg::CMD_SEND:
                        begin
                            if (full_reg)
                            begin
                                result_next.kind = gbn_pkg::KIND_REFUSED;
                            end
                            else
                            begin
                                we        = 1'b1;
                                nseq_next = seq_inc;
                                full_next = ((base_reg + gbn_pkg::WINDOW_MOD) == seq_inc);
                                result_next.kind        = gbn_pkg::KIND_NEW;
                                result_next.seq         = nseq_reg;
                                result_next.data_out    = item_reg.payload & gbn_pkg::DATA_MASK;
                                result_next.timer_start = (nseq_reg == base_reg);
                                result_next.timer_seq   = (nseq_reg == base_reg) ? nseq_reg
                                                                                 : '0;
                                result_next.window_full = full_next;
                            end
                        end
                        gbn_pkg::CMD_ACK:
                        begin
                            if (!item_reg.ack_good)
                            begin
                                result_next.kind = gbn_pkg::KIND_IGNORED;
                            end
                            else if ({1'b0, off} < cnt)
                            begin
                                dup_next  = '0;
                                base_next = base_new;
                                full_next = 1'b0;
                                result_next.kind        = gbn_pkg::KIND_ACK_OK;
                                result_next.seq         = item_reg.ack_num;
                                result_next.timer_stop  = 1'b1;
                                result_next.timer_seq   = base_reg;
                                result_next.window_full = 1'b0;
                                result_next.last        = (base_new == nseq_reg);
                                if (base_new != nseq_reg)
                                begin
                                    state_next = ST_ACK2;
                                end
                            end
                            else if (item_reg.ack_num == base_reg - 1'b1)
                            begin
                                if (dup_reg == gbn_pkg::DUP_LAST)
                                begin
                                    dup_next = '0;
                                    if (cnt == '0)
                                    begin
                                        result_next.timer_stop = 1'b1;
                                        result_next.timer_seq  = base_reg;
                                    end
                                    else
                                    begin
                                        emit         = 1'b0;
                                        state_next   = ST_RESEND;
                                        idx_next     = '0;
                                        rs_n_next    = cnt;
                                        rs_tseq_next = base_reg;
                                    end
                                end
                                else
                                begin
                                    dup_next = dup_reg + 1'b1;
                                end
                            end
                        end
                        gbn_pkg::CMD_TIMEOUT:
                        begin
                            dup_next = '0;
                            if (cnt == '0)
                            begin
                                result_next.kind        = gbn_pkg::KIND_IDLE_TO;
                                result_next.timer_stop  = 1'b1;
                                result_next.timer_start = 1'b1;
                                result_next.timer_seq   = item_reg.timeout_seq;
                            end
                            else
                            begin
                                emit         = 1'b0;
                                state_next   = ST_RESEND;
                                idx_next     = '0;
                                rs_n_next    = cnt;
                                rs_tseq_next = item_reg.timeout_seq;
                            end
                        end
                        default:
                        begin
                            result_next.kind = gbn_pkg::KIND_IGNORED;
                        end
                    endcase
                end
            end
            ST_ACK2:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    result_next.kind        = gbn_pkg::KIND_ACK_OK;
                    result_next.seq         = item_reg.ack_num;
                    result_next.timer_start = 1'b1;
                    result_next.timer_seq   = base_reg;
                end
            end
            ST_RESEND:
            begin
                if (out_free)
                begin
                    emit  = 1'b1;
                    raddr = base_reg + idx_reg + 1'b1;
                    result_next.kind        = gbn_pkg::KIND_RESENT;
                    result_next.seq         = base_reg + idx_reg;
                    result_next.data_out    = rdata & gbn_pkg::DATA_MASK;
                    result_next.timer_stop  = (idx_reg == '0);
                    result_next.timer_start = rs_final;
                    result_next.timer_seq   = rs_tseq_reg;
                    result_next.last        = rs_final;
                    if (rs_final)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            base_reg         <= '0;
            nseq_reg         <= '0;
            full_reg         <= 1'b0;
            dup_reg          <= '0;
            idx_reg          <= '0;
            rs_n_reg         <= '0;
            rs_tseq_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            base_reg         <= base_next;
            nseq_reg         <= nseq_next;
            full_reg         <= full_next;
            dup_reg          <= dup_next;
            idx_reg          <= idx_next;
            rs_n_reg         <= rs_n_next;
            rs_tseq_reg      <= rs_tseq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_valid)
        begin
            item_reg <= item;
        end
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    a_full_means_window: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (nseq_reg - base_reg) == gbn_pkg::WINDOW_MOD)
        else $error("full flag set without a full window");

    a_dup_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        dup_reg != 2'd3)
        else $error("duplicate count overran");

    a_resend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESEND |-> ({1'b0, idx_reg} < rs_n_reg && !we))
        else $error("retransmission walk out of range");

endmodule

`default_nettype wire

FILE: tb/go_back_n_sender_window_check.sv
`default_nettype none

module go_back_n_sender_window_check
    import gbn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic       item_ready,
    input  wire item_t      item,
    input  wire logic       result_valid,
    input  wire logic       result_ready,
    input  wire result_t    result,
    output int              mismatches,
    output int              pending,
    output logic [SEQ_W-1:0] base_hint,
    output logic [SEQ_W-1:0] next_hint
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUP_LIMIT = 3;
    localparam int PRINT_CAP = 60;

    logic [63:0]      sent_words [SEQ_SPACE];
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] next_free;
    logic             full;
    int               dups;
    int               beat_no;
    result_t          reply [$];
    result_t          awaited [$];
    result_t          want;
    string            bad;

    assign base_hint = base;
    assign next_hint = next_free;

    task automatic report(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic result_t beat(input logic [2:0] kind, input logic [SEQ_W-1:0] seq,
                                     input logic [63:0] data, input logic stop,
                                     input logic start, input logic [SEQ_W-1:0] tseq);
        result_t b;
        b = '0;
        b.kind        = kind;
        b.seq         = seq;
        b.data_out    = data & DATA_MASK;
        b.timer_stop  = stop;
        b.timer_start = start;
        b.timer_seq   = tseq;
        return b;
    endfunction

    function automatic int in_flight();
        int n;
        n = (next_free + SEQ_SPACE - base) % SEQ_SPACE;
        if (n == 0 && full)
            n = SEQ_SPACE;
        return n;
    endfunction

    // go back to the base and replay every outstanding packet
    task automatic replay_window(input logic [SEQ_W-1:0] tag);
        int n;
        logic [SEQ_W-1:0] s;
        n = in_flight();
        for (int i = 0; i < n; i++)
        begin
            s = SEQ_W'((base + i) % SEQ_SPACE);
            reply.push_back(beat(KIND_RESENT, s, sent_words[s], i == 0, i == n - 1, tag));
        end
    endtask

    task automatic predict_replies(input item_t it);
        int               cnt;
        int               off;
        logic             was_empty;
        logic [SEQ_W-1:0] old;
        reply.delete();
        case (it.cmd)
            CMD_SEND:
            begin
                if (full)
                    reply.push_back(beat(KIND_REFUSED, '0, '0, 1'b0, 1'b0, '0));
                else
                begin
                    was_empty = (next_free == base);
                    sent_words[next_free] = it.payload & DATA_MASK;
                    reply.push_back(beat(KIND_NEW, next_free, it.payload, 1'b0, was_empty,
                                         was_empty ? next_free : '0));
                    next_free = SEQ_W'((next_free + 1) % SEQ_SPACE);
                    if (SEQ_W'((base + WINDOW) % SEQ_SPACE) == next_free)
                        full = 1'b1;
                end
            end
            CMD_ACK:
            begin
                cnt = in_flight();
                off = (it.ack_num + SEQ_SPACE - base) % SEQ_SPACE;
                if (!it.ack_good)
                    reply.push_back(beat(KIND_IGNORED, '0, '0, 1'b0, 1'b0, '0));
                else if (off < cnt)
                begin
                    old = base;
                    dups = 0;
                    base = SEQ_W'((it.ack_num + 1) % SEQ_SPACE);
                    full = 1'b0;
                    reply.push_back(beat(KIND_ACK_OK, it.ack_num, '0, 1'b1, 1'b0, old));
                    if (base != next_free)
                        reply.push_back(beat(KIND_ACK_OK, it.ack_num, '0, 1'b0, 1'b1, base));
                end
                else if (it.ack_num == SEQ_W'((base + SEQ_SPACE - 1) % SEQ_SPACE))
                begin
                    dups++;
                    if (dups >= DUP_LIMIT)
                    begin
                        dups = 0;
                        if (cnt == 0)
                            reply.push_back(beat(KIND_IGNORED, '0, '0, 1'b1, 1'b0, base));
                        else
                            replay_window(base);
                    end
                    else
                        reply.push_back(beat(KIND_IGNORED, '0, '0, 1'b0, 1'b0, '0));
                end
                else
                    reply.push_back(beat(KIND_IGNORED, '0, '0, 1'b0, 1'b0, '0));
            end
            CMD_TIMEOUT:
            begin
                dups = 0;
                if (in_flight() == 0)
                    reply.push_back(beat(KIND_IDLE_TO, '0, '0, 1'b1, 1'b1, it.timeout_seq));
                else
                    replay_window(it.timeout_seq);
            end
            default:
                reply.push_back(beat(KIND_IGNORED, '0, '0, 1'b0, 1'b0, '0));
        endcase
        foreach (reply[i])
        begin
            reply[i].window_full = full;
            reply[i].last        = (i == reply.size() - 1);
            awaited.push_back(reply[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base      = '0;
            next_free = '0;
            full      = 1'b0;
            dups      = 0;
            beat_no   = 0;
            foreach (sent_words[i])
                sent_words[i] = '0;
            awaited.delete();
            pending   = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (awaited.size() == 0)
                    report($sformatf("result beat %0d with nothing awaited: %h", beat_no, result));
                else
                begin
                    want = awaited.pop_front();
                    bad  = "";
                    if (result.kind !== want.kind)               bad = {bad, " kind"};
                    if (result.seq !== want.seq)                 bad = {bad, " seq"};
                    if (result.data_out !== want.data_out)       bad = {bad, " data_out"};
                    if (result.timer_stop !== want.timer_stop)   bad = {bad, " timer_stop"};
                    if (result.timer_start !== want.timer_start) bad = {bad, " timer_start"};
                    if (result.timer_seq !== want.timer_seq)     bad = {bad, " timer_seq"};
                    if (result.window_full !== want.window_full) bad = {bad, " window_full"};
                    if (result.last !== want.last)               bad = {bad, " last"};
                    if (bad != "")
                        report($sformatf("result beat %0d wrong in%s: got %h expected %h",
                                         beat_no, bad, result, want));
                end
                beat_no++;
            end
            if (item_valid && item_ready)
                predict_replies(item);
            pending = awaited.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/go_back_n_sender_window_test.sv
`default_nettype none

module go_back_n_sender_window_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 320;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 24;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    item_t            item;
    logic             result_valid;
    logic             result_ready;
    result_t          result;
    int               mismatches;
    int               pending;
    logic [SEQ_W-1:0] base_hint;
    logic [SEQ_W-1:0] next_hint;
    int               cycles;
    int               issued;
    bit               calm;

    go_back_n_sender_window uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    go_back_n_sender_window_check watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending),
        .base_hint    (base_hint),
        .next_hint    (next_hint)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("go_back_n_sender_window regression: fail");
        $finish;
    end

    // result side stalls: long open stretches, short drops, the odd long hold
    initial
    begin : result_side
        int r;
        int span;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            result_ready = (r < 55);
            if (r < 55)
                span = $urandom_range(1, 24);
            else if (r < 92)
                span = $urandom_range(1, 3);
            else
                span = $urandom_range(8, 40);
            repeat (span) @(negedge clk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // unused fields carry noise
    function automatic item_t noisy_item(input logic [1:0] cmd);
        item_t it;
        it.cmd         = cmd;
        it.payload     = {$urandom, $urandom};
        it.ack_num     = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
        it.ack_good    = 1'($urandom_range(0, 1));
        it.timeout_seq = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
        return it;
    endfunction

    task automatic offer(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
        issued++;
    endtask

    task automatic offer_send(input logic [63:0] word);
        item_t it;
        it         = noisy_item(CMD_SEND);
        it.payload = word;
        offer(it);
    endtask

    task automatic offer_ack(input logic [SEQ_W-1:0] num, input logic good);
        item_t it;
        it          = noisy_item(CMD_ACK);
        it.ack_num  = num;
        it.ack_good = good;
        offer(it);
    endtask

    task automatic offer_expiry(input logic [SEQ_W-1:0] tseq);
        item_t it;
        it             = noisy_item(CMD_TIMEOUT);
        it.timeout_seq = tseq;
        offer(it);
    endtask

    initial
    begin : stimulus
        int r;
        int span;
        logic [SEQ_W-1:0] dup_num;
        item_t it;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        issued     = 0;
        calm       = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty window corners
        offer_expiry(3'd7);
        offer_ack(3'd3, 1'b0);
        repeat (3) offer_ack(3'd7, 1'b1);
        it          = noisy_item(CMD_SPARE);
        it.payload  = '1;
        it.ack_num  = '1;
        it.ack_good = 1'b1;
        offer(it);
        // fill the window, then one refused; then replays, acknowledgements and duplicates
        offer_send('1);
        offer_send('0);
        offer_send(64'h8000_0000_0000_0000);
        offer_send(64'h0000_0000_0000_0001);
        offer_send(64'h5a5a_a5a5_0f0f_f0f0);
        offer_expiry(3'd0);
        offer_ack(3'd5, 1'b1);
        repeat (3) offer_ack(3'd7, 1'b1);
        offer_ack(3'd1, 1'b1);
        offer_ack(3'd1, 1'b1);
        offer_ack(3'd3, 1'b1);
        offer_send(64'ha5a5_5a5a_f0f0_0f0f);
        offer_ack(3'd4, 1'b1);

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (issued % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45)
                offer_send(pick_word());
            else if (r < 75)
            begin
                span = (next_hint + SEQ_SPACE - base_hint) % SEQ_SPACE;
                if (span == 0)
                    offer_ack(SEQ_W'($urandom_range(0, SEQ_SPACE - 1)), 1'b1);
                else
                    offer_ack(SEQ_W'(base_hint + $urandom_range(0, span - 1)),
                              $urandom_range(0, 9) != 0);
            end
            else if (r < 85)
            begin
                // duplicate run against base minus one, now and then broken
                dup_num = SEQ_W'(base_hint + SEQ_SPACE - 1);
                repeat (3) offer_ack(dup_num, $urandom_range(0, 7) != 0);
            end
            else if (r < 95)
                offer_expiry(SEQ_W'($urandom_range(0, SEQ_SPACE - 1)));
            else if (r < 99)
                offer(noisy_item(CMD_ACK));
            else
                offer(noisy_item(CMD_SPARE));
        end
        item_valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("go_back_n_sender_window regression: pass");
        else
            $display("go_back_n_sender_window regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_store.sv
hw/rtl/go_back_n_sender_window.sv
tb/go_back_n_sender_window_check.sv
tb/go_back_n_sender_window_test.sv
